// ===== rtl/urc_pkg.sv =====
// Shared types, result codes and prefix tables for the modem URC line parser.
`timescale 1ns / 1ps

package urc_pkg;

  // One accepted input word: a text byte and its end-of-chunk mark.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       chunk_end;
  } text_t;

  // One result word, emitted per finished line.
  typedef struct packed {
    logic [3:0]         line_kind;
    logic               status_updated;
    logic               is_registered;
    logic               is_attached;
    logic               in_call;
    logic signed [15:0] signal_level;
    logic [31:0]        update_total;
  } urc_t;

  // Summary of the line handed from the scanner to the status keeper.
  typedef struct packed {
    logic               line_end;
    logic [3:0]         kind;
    logic               have_num;
    logic               status_ok;
    logic signed [15:0] first_num;
    logic               saw_one;
  } scan_t;

  localparam logic [3:0] KIND_NONE  = 4'd0;
  localparam logic [3:0] KIND_CEREG = 4'd1;
  localparam logic [3:0] KIND_CGATT = 4'd2;
  localparam logic [3:0] KIND_CSQ   = 4'd3;
  localparam logic [3:0] KIND_CLIP  = 4'd4;
  localparam logic [3:0] KIND_BEGIN = 4'd5;
  localparam logic [3:0] KIND_END   = 4'd6;
  localparam logic [3:0] KIND_CALL  = 4'd7;
  localparam logic [3:0] KIND_CMTI  = 4'd8;

  // Prefix slots, in table order.
  localparam int PFX_NUM   = 8;
  localparam int PFX_CHARS = 17;

  localparam logic [2:0] PFX_CEREG = 3'd0;
  localparam logic [2:0] PFX_CGATT = 3'd1;
  localparam logic [2:0] PFX_CSQ   = 3'd2;
  localparam logic [2:0] PFX_CLIP  = 3'd3;
  localparam logic [2:0] PFX_CALL  = 3'd4;
  localparam logic [2:0] PFX_CMTI  = 3'd5;
  localparam logic [2:0] PFX_BEGIN = 3'd6;
  localparam logic [2:0] PFX_END   = 3'd7;

  // Each prefix left-aligned in a 17-character field, padded with spaces.
  localparam logic [8*PFX_CHARS-1:0] PFX_TEXT [PFX_NUM] = '{
    {"+CEREG:",            {10{8'h20}}},
    {"+CGATT:",            {10{8'h20}}},
    {"+CSQ:",              {12{8'h20}}},
    {"+CLIP:",             {11{8'h20}}},
    {"VOICE CALL:",        { 6{8'h20}}},
    {"+CMTI:",             {11{8'h20}}},
    {"VOICE CALL: BEGIN"},
    {"VOICE CALL: END",    { 2{8'h20}}}
  };

  localparam logic [4:0] PFX_LEN [PFX_NUM] = '{
    5'd7, 5'd7, 5'd5, 5'd6, 5'd11, 5'd6, 5'd17, 5'd15
  };

  // Character p of prefix k; positions past the field read as the first character.
  function automatic logic [7:0] pfx_char(input logic [2:0] k, input logic [4:0] p);
    logic [4:0] q;
    q = (p < 5'(PFX_CHARS)) ? (5'(PFX_CHARS - 1) - p) : 5'(PFX_CHARS - 1);
    return PFX_TEXT[k][8*q +: 8];
  endfunction

endpackage

// ===== rtl/urc_scan.sv =====
// Per-line scanner: skips leading blanks, tracks prefix matches and parses numbers.
`timescale 1ns / 1ps

module urc_scan (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  urc_pkg::text_t word,
  output urc_pkg::scan_t scan
);
  import urc_pkg::*;

  localparam logic [2:0] PH_PREFIX = 3'd0;
  localparam logic [2:0] PH_LEAD1  = 3'd1;
  localparam logic [2:0] PH_SIGN1  = 3'd2;
  localparam logic [2:0] PH_DIG1   = 3'd3;
  localparam logic [2:0] PH_LEAD2  = 3'd4;
  localparam logic [2:0] PH_SIGN2  = 3'd5;
  localparam logic [2:0] PH_DIG2   = 3'd6;
  localparam logic [2:0] PH_DONE   = 3'd7;

  localparam logic [4:0] POS_MAX = 5'd31;

  logic               before_content;
  logic [4:0]         char_position;
  logic [7:0]         prefix_candidates;
  logic [2:0]         parse_phase;
  logic signed [15:0] first_number;
  logic signed [15:0] second_number;
  logic               number_negative;
  logic [1:0]         numbers_found;
  logic               saw_digit_one;

  logic               before_content_next;
  logic [4:0]         char_position_next;
  logic [7:0]         prefix_candidates_next;
  logic [2:0]         parse_phase_next;
  logic signed [15:0] first_number_next;
  logic signed [15:0] second_number_next;
  logic               number_negative_next;
  logic [1:0]         numbers_found_next;
  logic               saw_digit_one_next;

  logic [7:0]  c;
  logic        is_nl;
  logic        line_end;
  logic        absorb;
  logic        is_ws;
  logic        is_digit;
  logic        is_sign;
  logic [3:0]  dval;
  logic [7:0]  hit;
  logic signed [15:0] status_sel;

  // Multiply by ten, add or subtract a digit, clamp to 16-bit signed.
  function automatic logic signed [15:0] add_digit(input logic signed [15:0] v,
                                                   input logic [3:0] d,
                                                   input logic neg);
    logic signed [20:0] x;
    logic signed [20:0] dx;
    x  = ({{5{v[15]}}, v} <<< 3) + ({{5{v[15]}}, v} <<< 1);
    dx = $signed({17'd0, d});
    x  = neg ? (x - dx) : (x + dx);
    if (x > 21'sd32767) begin
      return 16'sh7FFF;
    end else if (x < -21'sd32768) begin
      return 16'sh8000;
    end
    return x[15:0];
  endfunction

  always_comb begin
    c        = word.text_byte;
    is_nl    = (c == 8'h0A);
    line_end = is_nl || word.chunk_end;
    absorb   = !is_nl && !(before_content && (c == 8'h0D || c == 8'h20));
    is_ws    = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    is_digit = (c >= "0") && (c <= "9");
    is_sign  = (c == "+") || (c == "-");
    dval     = c[3:0];

    before_content_next    = before_content;
    char_position_next     = char_position;
    prefix_candidates_next = prefix_candidates;
    parse_phase_next       = parse_phase;
    first_number_next      = first_number;
    second_number_next     = second_number;
    number_negative_next   = number_negative;
    numbers_found_next     = numbers_found;
    saw_digit_one_next     = saw_digit_one;

    if (absorb) begin
      before_content_next = 1'b0;
      if (c == "1") begin
        saw_digit_one_next = 1'b1;
      end

      // Number parse, driven by the phase held before this byte.
      unique case (parse_phase)
        PH_LEAD1, PH_LEAD2: begin
          if (!is_ws) begin
            if (is_sign) begin
              number_negative_next = (c == "-");
              parse_phase_next     = parse_phase + 3'd1;
            end else if (is_digit) begin
              number_negative_next = 1'b0;
              numbers_found_next   = (numbers_found == 2'd3) ? 2'd3 : numbers_found + 2'd1;
              if (parse_phase == PH_LEAD2) begin
                second_number_next = add_digit(16'sd0, dval, 1'b0);
                parse_phase_next   = PH_DIG2;
              end else begin
                first_number_next = add_digit(16'sd0, dval, 1'b0);
                parse_phase_next  = PH_DIG1;
              end
            end else begin
              parse_phase_next = PH_DONE;
            end
          end
        end
        PH_SIGN1, PH_SIGN2: begin
          if (is_digit) begin
            numbers_found_next = (numbers_found == 2'd3) ? 2'd3 : numbers_found + 2'd1;
            if (parse_phase == PH_SIGN2) begin
              second_number_next = add_digit(16'sd0, dval, number_negative);
              parse_phase_next   = PH_DIG2;
            end else begin
              first_number_next = add_digit(16'sd0, dval, number_negative);
              parse_phase_next  = PH_DIG1;
            end
          end else begin
            parse_phase_next = PH_DONE;
          end
        end
        PH_DIG1: begin
          if (is_digit) begin
            first_number_next = add_digit(first_number, dval, number_negative);
          end else if (c == "," && prefix_candidates[PFX_CEREG]) begin
            parse_phase_next     = PH_LEAD2;
            number_negative_next = 1'b0;
          end else begin
            parse_phase_next = PH_DONE;
          end
        end
        PH_DIG2: begin
          if (is_digit) begin
            second_number_next = add_digit(second_number, dval, number_negative);
          end else begin
            parse_phase_next = PH_DONE;
          end
        end
        default: begin
        end
      endcase

      // Drop every prefix whose character at this position differs.
      for (int k = 0; k < PFX_NUM; k++) begin
        if (char_position < PFX_LEN[k] && c != pfx_char(3'(k), char_position)) begin
          prefix_candidates_next[k] = 1'b0;
        end
      end

      char_position_next = (char_position < POS_MAX) ? char_position + 5'd1 : char_position;

      if (parse_phase == PH_PREFIX) begin
        if (prefix_candidates_next[PFX_CEREG] && char_position_next == PFX_LEN[PFX_CEREG]) begin
          parse_phase_next = PH_LEAD1;
        end else if (prefix_candidates_next[PFX_CSQ] &&
                     char_position_next == PFX_LEN[PFX_CSQ]) begin
          parse_phase_next = PH_LEAD1;
        end
      end
    end

    for (int k = 0; k < PFX_NUM; k++) begin
      hit[k] = prefix_candidates_next[k] && (char_position_next >= PFX_LEN[k]);
    end

    status_sel = (numbers_found_next >= 2'd2) ? second_number_next : first_number_next;

    scan.line_end  = line_end;
    scan.have_num  = (numbers_found_next != 2'd0);
    scan.status_ok = (status_sel == 16'sd1) || (status_sel == 16'sd5);
    scan.first_num = first_number_next;
    scan.saw_one   = saw_digit_one_next;
    if (hit[PFX_CEREG]) begin
      scan.kind = KIND_CEREG;
    end else if (hit[PFX_CGATT]) begin
      scan.kind = KIND_CGATT;
    end else if (hit[PFX_BEGIN]) begin
      scan.kind = KIND_BEGIN;
    end else if (hit[PFX_END]) begin
      scan.kind = KIND_END;
    end else if (hit[PFX_CSQ]) begin
      scan.kind = KIND_CSQ;
    end else if (hit[PFX_CLIP]) begin
      scan.kind = KIND_CLIP;
    end else if (hit[PFX_CALL]) begin
      scan.kind = KIND_CALL;
    end else if (hit[PFX_CMTI]) begin
      scan.kind = KIND_CMTI;
    end else begin
      scan.kind = KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && line_end)) begin
      before_content    <= 1'b1;
      char_position     <= 5'd0;
      prefix_candidates <= 8'hFF;
      parse_phase       <= PH_PREFIX;
      first_number      <= 16'sd0;
      second_number     <= 16'sd0;
      number_negative   <= 1'b0;
      numbers_found     <= 2'd0;
      saw_digit_one     <= 1'b0;
    end else if (step) begin
      before_content    <= before_content_next;
      char_position     <= char_position_next;
      prefix_candidates <= prefix_candidates_next;
      parse_phase       <= parse_phase_next;
      first_number      <= first_number_next;
      second_number     <= second_number_next;
      number_negative   <= number_negative_next;
      numbers_found     <= numbers_found_next;
      saw_digit_one     <= saw_digit_one_next;
    end
  end

endmodule

// ===== rtl/urc_status.sv =====
// Kept modem status: registration, attach, call, signal level and update count.
`timescale 1ns / 1ps

module urc_status (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  urc_pkg::scan_t scan,
  output urc_pkg::urc_t  res
);
  import urc_pkg::*;

  logic               registered_flag;
  logic               attached_flag;
  logic               call_flag;
  logic signed [15:0] signal_value;
  logic [31:0]        update_count;

  logic               registered_flag_next;
  logic               attached_flag_next;
  logic               call_flag_next;
  logic signed [15:0] signal_value_next;
  logic [31:0]        update_count_next;
  logic               upd;

  always_comb begin
    registered_flag_next = registered_flag;
    attached_flag_next   = attached_flag;
    call_flag_next       = call_flag;
    signal_value_next    = signal_value;

    case (scan.kind) inside
      KIND_CEREG, KIND_CGATT, KIND_CSQ, KIND_BEGIN, KIND_END: upd = 1'b1;
      default:                                                upd = 1'b0;
    endcase

    case (scan.kind)
      KIND_CEREG: begin
        if (scan.have_num) begin
          registered_flag_next = scan.status_ok;
        end
      end
      KIND_CGATT: attached_flag_next = scan.saw_one;
      KIND_BEGIN: call_flag_next = 1'b1;
      KIND_END:   call_flag_next = 1'b0;
      KIND_CSQ: begin
        if (scan.have_num) begin
          signal_value_next = scan.first_num;
        end
      end
      default: begin
      end
    endcase

    update_count_next = upd ? update_count + 32'd1 : update_count;

    res.line_kind      = scan.kind;
    res.status_updated = upd;
    res.is_registered  = registered_flag_next;
    res.is_attached    = attached_flag_next;
    res.in_call        = call_flag_next;
    res.signal_level   = signal_value_next;
    res.update_total   = update_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      registered_flag <= 1'b0;
      attached_flag   <= 1'b0;
      call_flag       <= 1'b0;
      signal_value    <= 16'sd0;
      update_count    <= 32'd0;
    end else if (step && scan.line_end) begin
      registered_flag <= registered_flag_next;
      attached_flag   <= attached_flag_next;
      call_flag       <= call_flag_next;
      signal_value    <= signal_value_next;
      update_count    <= update_count_next;
    end
  end

endmodule

// ===== rtl/modem_urc_line_parser.sv =====
// Top level of the modem unsolicited-result line parser.
`timescale 1ns / 1ps

// Usage:
//   text channel (text_valid / text_ready / text): one word per byte of modem
//   response text plus a chunk_end mark. A newline, or a word with chunk_end
//   set, finishes the current line.
//   urc channel (urc_valid / urc_ready / urc): one word per finished line with
//   its kind, whether it advanced the update count, and the kept status after it.
// Timing:
//   An accepted word lands in the input register; from there it runs through
//   the scanner and status logic and, if it ends a line, the result is loaded
//   into the output register. One text word per cycle is sustained unless a
//   line-ending word is held behind a waiting result; the rate is set by the
//   single pass from input register to output register.
// Reset (rst, synchronous): clears both registers' valid bits, the per-line
//   scan state and all kept status, update count included.
// Stall: while urc_ready is low and a result waits, a word that does not end
//   a line still advances; a line-ending word holds in the input register, and
//   text_ready drops only then.

module modem_urc_line_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           text_valid,
  output logic           text_ready,
  input  urc_pkg::text_t text,
  output logic           urc_valid,
  input  logic           urc_ready,
  output urc_pkg::urc_t  urc
);
  import urc_pkg::*;

  // Input register.
  logic  in_valid;
  text_t in_word;

  // Handshake between the stages.
  logic  out_free;
  logic  advance;
  scan_t scan;
  urc_t  res;

  // Output slot is free when empty or being drained this cycle.
  assign out_free   = !urc_valid || urc_ready;
  // Advance the held word unless it ends a line and the output slot is busy.
  assign advance    = in_valid && (!scan.line_end || out_free);
  assign text_ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text_ready) begin
      in_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && text_ready) begin
      in_word <= text;
    end
  end

  urc_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .word (in_word),
    .scan (scan)
  );

  urc_status u_status (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .scan (scan),
    .res  (res)
  );

  // Output register: load on a line end, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      urc_valid <= 1'b0;
    end else if (advance && scan.line_end) begin
      urc_valid <= 1'b1;
    end else if (urc_ready) begin
      urc_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && scan.line_end) begin
      urc <= res;
    end
  end

  // A line end that advances always leaves a result waiting.
  a_line_end_loads: assert property (@(posedge clk) disable iff (rst)
    (advance && scan.line_end) |=> urc_valid)
    else $error("line end did not load a result");

  // Input stalls only behind a line-ending word blocked by a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !text_ready |-> (in_valid && scan.line_end && urc_valid && !urc_ready))
    else $error("input stalled without a blocked line end");

  // Only status-bearing kinds may report an update.
  a_update_kind: assert property (@(posedge clk) disable iff (rst)
    (urc_valid && urc.status_updated) |->
      (urc.line_kind == KIND_CEREG || urc.line_kind == KIND_CGATT ||
       urc.line_kind == KIND_CSQ || urc.line_kind == KIND_BEGIN ||
       urc.line_kind == KIND_END))
    else $error("update reported for a kind that carries no status");

  // The loaded result carries the count the status logic produced for its line.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (advance && scan.line_end) |=>
      (urc.update_total == $past(res.update_total)))
    else $error("result count differs from the status count");

endmodule
